@@ hw/rtl/qrs_pkg.sv @@
// Shared types and constants for the quadratic root solver.
`default_nettype none
package qrs_pkg;

    localparam int OUT_BITS = 41;

    typedef enum logic [1:0] {
        KIND_REPEATED = 2'd0,
        KIND_TWO_REAL = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_INVALID  = 2'd3
    } t_root_kind;

endpackage
`default_nettype wire

@@ hw/rtl/qrs_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
`default_nettype none
module qrs_sqrt #(
    parameter int RAD_W  = 66,
    parameter int SIDE_W = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [RAD_W-1:0]     i_rad,
    input  wire logic [SIDE_W-1:0]    i_side,
    output logic                      o_valid,
    output logic [RAD_W/2-1:0]        o_root,
    output logic [SIDE_W-1:0]         o_side
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STG    = ROOT_W;

    logic              s_vld  [0:STG];
    logic [RAD_W-1:0]  s_rad  [0:STG];
    logic [REM_W-1:0]  s_rem  [0:STG];
    logic [ROOT_W-1:0] s_root [0:STG];
    logic [SIDE_W-1:0] s_side [0:STG];

    assign s_vld[0]  = i_valid;
    assign s_rad[0]  = i_rad;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < STG; k++) begin : g_stage
        logic              r_vld;
        logic [RAD_W-1:0]  r_rad;
        logic [REM_W-1:0]  r_rem;
        logic [ROOT_W-1:0] r_root;
        logic [SIDE_W-1:0] r_side;
        logic [REM_W-1:0]  n_rem_sh;
        logic [REM_W-1:0]  n_trial;
        logic              n_take;

        always_comb begin
            // bring down the next two radicand bits and try root*4+1
            n_rem_sh = {s_rem[k][REM_W-3:0], s_rad[k][RAD_W-1 -: 2]};
            n_trial  = {s_root[k], 2'b01};
            n_take   = (n_rem_sh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= s_vld[k];
            end
            r_rad  <= s_rad[k] << 2;
            r_rem  <= n_take ? (n_rem_sh - n_trial) : n_rem_sh;
            r_root <= {s_root[k][ROOT_W-2:0], n_take};
            r_side <= s_side[k];
        end

        assign s_vld[k+1]  = r_vld;
        assign s_rad[k+1]  = r_rad;
        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_side[k+1] = r_side;
    end

    assign o_valid = s_vld[STG];
    assign o_root  = s_root[STG];
    assign o_side  = s_side[STG];
endmodule
`default_nettype wire

@@ hw/rtl/qrs_div.sv @@
// Pipelined two-lane restoring divider sharing one divisor, one quotient bit per stage.
`default_nettype none
module qrs_div #(
    parameter int NUM_W  = 34,
    parameter int DEN_W  = 17,
    parameter int SIDE_W = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [NUM_W-1:0]     i_num1,
    input  wire logic [NUM_W-1:0]     i_num2,
    input  wire logic [DEN_W-1:0]     i_den,
    input  wire logic [SIDE_W-1:0]    i_side,
    output logic                      o_valid,
    output logic [NUM_W-1:0]          o_quo1,
    output logic [NUM_W-1:0]          o_quo2,
    output logic [SIDE_W-1:0]         o_side
);
    localparam int STG = NUM_W;

    logic              s_vld  [0:STG];
    logic [NUM_W-1:0]  s_n1   [0:STG];
    logic [NUM_W-1:0]  s_n2   [0:STG];
    logic [DEN_W-1:0]  s_rem1 [0:STG];
    logic [DEN_W-1:0]  s_rem2 [0:STG];
    logic [DEN_W-1:0]  s_den  [0:STG];
    logic [SIDE_W-1:0] s_side [0:STG];

    assign s_vld[0]  = i_valid;
    assign s_n1[0]   = i_num1;
    assign s_n2[0]   = i_num2;
    assign s_rem1[0] = '0;
    assign s_rem2[0] = '0;
    assign s_den[0]  = i_den;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < STG; k++) begin : g_stage
        logic              r_vld;
        logic [NUM_W-1:0]  r_n1;
        logic [NUM_W-1:0]  r_n2;
        logic [DEN_W-1:0]  r_rem1;
        logic [DEN_W-1:0]  r_rem2;
        logic [DEN_W-1:0]  r_den;
        logic [SIDE_W-1:0] r_side;
        logic [DEN_W:0]    n_sh1;
        logic [DEN_W:0]    n_sh2;
        logic [DEN_W:0]    n_dx;
        logic              n_q1;
        logic              n_q2;

        always_comb begin
            n_dx  = {1'b0, s_den[k]};
            n_sh1 = {s_rem1[k], s_n1[k][NUM_W-1]};
            n_sh2 = {s_rem2[k], s_n2[k][NUM_W-1]};
            n_q1  = (n_sh1 >= n_dx);
            n_q2  = (n_sh2 >= n_dx);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= s_vld[k];
            end
            // shift the quotient bit in as the numerator bit leaves
            r_n1   <= {s_n1[k][NUM_W-2:0], n_q1};
            r_n2   <= {s_n2[k][NUM_W-2:0], n_q2};
            r_rem1 <= n_q1 ? DEN_W'(n_sh1 - n_dx) : DEN_W'(n_sh1);
            r_rem2 <= n_q2 ? DEN_W'(n_sh2 - n_dx) : DEN_W'(n_sh2);
            r_den  <= s_den[k];
            r_side <= s_side[k];
        end

        assign s_vld[k+1]  = r_vld;
        assign s_n1[k+1]   = r_n1;
        assign s_n2[k+1]   = r_n2;
        assign s_rem1[k+1] = r_rem1;
        assign s_rem2[k+1] = r_rem2;
        assign s_den[k+1]  = r_den;
        assign s_side[k+1] = r_side;
    end

    assign o_valid = s_vld[STG];
    assign o_quo1  = s_n1[STG];
    assign o_quo2  = s_n2[STG];
    assign o_side  = s_side[STG];
endmodule
`default_nettype wire

@@ hw/rtl/quadratic_root_solver.sv @@
// Registers in order: products, discriminant, square-root stages, numerators, divider
// stages, output; one stage per root bit, one per quotient bit.
// Throughput: one coefficient set per cycle; busy stays low and results never stall.
// Reset (synchronous, active low) clears every valid bit; items in flight are dropped.
// Top level: products, discriminant, square root, numerators, division, saturation.
`default_nettype none
module quadratic_root_solver #(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COEF_BITS-1:0]   i_coef_a,
    input  wire logic signed [COEF_BITS-1:0]   i_coef_b,
    input  wire logic signed [COEF_BITS-1:0]   i_coef_c,
    output logic                               o_valid,
    output logic [1:0]                         o_root_kind,
    output logic signed [qrs_pkg::OUT_BITS-1:0] o_first_value,
    output logic signed [qrs_pkg::OUT_BITS-1:0] o_second_value
);
    import qrs_pkg::*;

    localparam int PW     = 2 * COEF_BITS;
    localparam int DW     = 2 * COEF_BITS + 1;
    localparam int RW     = DW + 2 * FRAC_BITS;
    localparam int RAD_W  = RW + (RW % 2);
    localparam int SB     = RAD_W / 2;
    localparam int NUMW   = SB + 2;
    localparam int NMW    = NUMW - 1;
    localparam int DEN_W  = COEF_BITS + 1;
    localparam int EW     = ((NMW > OUT_BITS) ? NMW : OUT_BITS) + 1;

    typedef struct packed {
        t_root_kind           kind;
        logic                 sgn_a;
        logic                 sgn_b;
        logic [COEF_BITS-1:0] mag_a;
        logic [COEF_BITS-1:0] mag_b;
    } t_side;

    typedef struct packed {
        t_root_kind kind;
        logic       sgn1;
        logic       sgn2;
    } t_dside;

    function automatic logic [COEF_BITS-1:0] f_mag(input logic [COEF_BITS-1:0] x);
        return x[COEF_BITS-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [OUT_BITS-1:0] f_sat(input logic [NMW-1:0] m, input logic neg);
        logic [EW-1:0] me;
        logic [EW-1:0] lim;
        logic [EW-1:0] sv;
        me  = EW'(m);
        lim = (EW'(1) << (OUT_BITS - 1)) - EW'(!neg);
        sv  = neg ? (~me + 1'b1) : me;
        if (me > lim) begin
            return neg ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
        end
        return sv[OUT_BITS-1:0];
    endfunction

    assign busy = 1'b0;

    // stage 1: magnitudes and products
    logic                 r1_vld;
    logic [PW-1:0]        r1_b2;
    logic [PW-1:0]        r1_ac;
    logic                 r1_sa;
    logic                 r1_sb;
    logic                 r1_sc;
    logic                 r1_azero;
    logic                 r1_czero;
    logic [COEF_BITS-1:0] r1_mag_a;
    logic [COEF_BITS-1:0] r1_mag_b;
    logic [COEF_BITS-1:0] n1_mag_a;
    logic [COEF_BITS-1:0] n1_mag_b;
    logic [COEF_BITS-1:0] n1_mag_c;

    always_comb begin
        n1_mag_a = f_mag(i_coef_a);
        n1_mag_b = f_mag(i_coef_b);
        n1_mag_c = f_mag(i_coef_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
        r1_b2    <= PW'(n1_mag_b) * PW'(n1_mag_b);
        r1_ac    <= PW'(n1_mag_a) * PW'(n1_mag_c);
        r1_sa    <= i_coef_a[COEF_BITS-1];
        r1_sb    <= i_coef_b[COEF_BITS-1];
        r1_sc    <= i_coef_c[COEF_BITS-1];
        r1_azero <= (i_coef_a == '0);
        r1_czero <= (i_coef_c == '0);
        r1_mag_a <= n1_mag_a;
        r1_mag_b <= n1_mag_b;
    end

    // stage 2: discriminant magnitude and root kind
    logic            r2_vld;
    logic [DW-1:0]   r2_d;
    t_side           r2_side;
    logic [PW+1:0]   n2_b2;
    logic [PW+1:0]   n2_p;
    logic [PW+1:0]   n2_d;
    logic            n2_neg;
    t_root_kind      n2_kind;

    always_comb begin
        n2_b2  = (PW+2)'(r1_b2);
        n2_p   = {r1_ac, 2'b00};
        n2_neg = 1'b0;
        if ((r1_sa != r1_sc) && !r1_czero) begin
            n2_d = n2_b2 + n2_p;
        end else if (n2_b2 >= n2_p) begin
            n2_d = n2_b2 - n2_p;
        end else begin
            n2_d   = n2_p - n2_b2;
            n2_neg = 1'b1;
        end
        if (r1_azero) begin
            n2_kind = KIND_INVALID;
        end else if (n2_d == '0) begin
            n2_kind = KIND_REPEATED;
        end else if (n2_neg) begin
            n2_kind = KIND_COMPLEX;
        end else begin
            n2_kind = KIND_TWO_REAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_d          <= n2_d[DW-1:0];
        r2_side.kind  <= n2_kind;
        r2_side.sgn_a <= r1_sa;
        r2_side.sgn_b <= r1_sb;
        r2_side.mag_a <= r1_mag_a;
        r2_side.mag_b <= r1_mag_b;
    end

    // square root of |D| scaled by 2^(2F)
    logic           sq_vld;
    logic [SB-1:0]  sq_root;
    t_side          sq_side;

    qrs_sqrt #(
        .RAD_W  (RAD_W),
        .SIDE_W ($bits(t_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_rad   (RAD_W'({r2_d, {(2*FRAC_BITS){1'b0}}})),
        .i_side  (r2_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // numerator stage: signed numerators turned to sign and magnitude
    logic              r3_vld;
    logic [NMW-1:0]    r3_m1;
    logic [NMW-1:0]    r3_m2;
    logic [DEN_W-1:0]  r3_den;
    t_dside            r3_side;
    logic signed [NUMW-1:0] n3_nbm;
    logic signed [NUMW-1:0] n3_nb;
    logic signed [NUMW-1:0] n3_s;
    logic signed [NUMW-1:0] n3_v1;
    logic signed [NUMW-1:0] n3_v2;

    always_comb begin
        n3_nbm = NUMW'(sq_side.mag_b) <<< FRAC_BITS;
        n3_nb  = sq_side.sgn_b ? n3_nbm : -n3_nbm;
        n3_s   = NUMW'(sq_root);
        n3_v1  = n3_nb;
        n3_v2  = '0;
        unique case (sq_side.kind)
            KIND_TWO_REAL: begin
                n3_v1 = n3_nb + n3_s;
                n3_v2 = n3_nb - n3_s;
            end
            KIND_COMPLEX: begin
                n3_v2 = n3_s;
            end
            KIND_REPEATED, KIND_INVALID: begin
                n3_v2 = '0;
            end
            default: begin
                n3_v2 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= sq_vld;
        end
        r3_m1        <= n3_v1[NUMW-1] ? NMW'(-n3_v1) : NMW'(n3_v1);
        r3_m2        <= n3_v2[NUMW-1] ? NMW'(-n3_v2) : NMW'(n3_v2);
        r3_den       <= {sq_side.mag_a, 1'b0};
        r3_side.kind <= sq_side.kind;
        r3_side.sgn1 <= n3_v1[NUMW-1] ^ sq_side.sgn_a;
        r3_side.sgn2 <= n3_v2[NUMW-1] ^ sq_side.sgn_a;
    end

    // division by 2|a|
    logic           dv_vld;
    logic [NMW-1:0] dv_q1;
    logic [NMW-1:0] dv_q2;
    t_dside         dv_side;

    qrs_div #(
        .NUM_W  (NMW),
        .DEN_W  (DEN_W),
        .SIDE_W ($bits(t_dside))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_vld),
        .i_num1  (r3_m1),
        .i_num2  (r3_m2),
        .i_den   (r3_den),
        .i_side  (r3_side),
        .o_valid (dv_vld),
        .o_quo1  (dv_q1),
        .o_quo2  (dv_q2),
        .o_side  (dv_side)
    );

    // output stage: restore sign, saturate, drop values for an invalid item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dv_vld;
        end
        o_root_kind <= dv_side.kind;
        if (dv_side.kind == KIND_INVALID) begin
            o_first_value  <= '0;
            o_second_value <= '0;
        end else begin
            o_first_value  <= f_sat(dv_q1, dv_side.sgn1);
            o_second_value <= f_sat(dv_q2, dv_side.sgn2);
        end
    end
endmodule
`default_nettype wire

@@ test/tb_quadratic_root_solver.sv @@
// Self-checking testbench for the quadratic root solver: directed and random coefficient sets.
`default_nettype none
module tb_quadratic_root_solver;
    import qrs_pkg::*;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int LATENCY = 71;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 1700;

    typedef struct {
        logic signed [CB-1:0] a;
        logic signed [CB-1:0] b;
        logic signed [CB-1:0] c;
    } t_coefs;

    typedef struct {
        t_root_kind                   kind;
        logic signed [OUT_BITS-1:0]   first;
        logic signed [OUT_BITS-1:0]   second;
    } t_roots;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CB-1:0] i_coef_a = '0;
    logic signed [CB-1:0] i_coef_b = '0;
    logic signed [CB-1:0] i_coef_c = '0;
    logic o_valid;
    logic [1:0] o_root_kind;
    logic signed [OUT_BITS-1:0] o_first_value;
    logic signed [OUT_BITS-1:0] o_second_value;

    t_coefs pending_sets[$];
    t_roots expected_roots[$];
    int     n_errors = 0;
    int     n_sent = 0;
    int     n_checked = 0;
    int     kind_seen[4] = '{0, 0, 0, 0};
    int     cycles = 0;

    quadratic_root_solver #(.COEF_BITS(CB), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_coef_a(i_coef_a), .i_coef_b(i_coef_b), .i_coef_c(i_coef_c),
        .o_valid(o_valid), .o_root_kind(o_root_kind),
        .o_first_value(o_first_value), .o_second_value(o_second_value)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] isqrt_floor(input logic [127:0] v);
        logic [63:0]  res;
        logic [63:0]  cand;
        logic [127:0] sq;
        res = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = res | (64'd1 << i);
            sq = 128'(cand) * 128'(cand);
            if (sq <= v) res = cand;
        end
        return res;
    endfunction

    function automatic logic signed [OUT_BITS-1:0] clamp_q(input longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (OUT_BITS - 1)) - 1;
        lo = -(64'sd1 <<< (OUT_BITS - 1));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[OUT_BITS-1:0];
    endfunction

    function automatic t_roots solve_roots(input t_coefs k);
        t_roots r;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint den;
        longint nb;
        longint s;
        logic [127:0] scaled;
        a = k.a;
        b = k.b;
        c = k.c;
        r.kind = KIND_INVALID;
        r.first = '0;
        r.second = '0;
        if (a == 0) return r;
        disc = b * b - 4 * a * c;
        if (disc == 0) begin
            r.kind = KIND_REPEATED;
        end else if (disc > 0) begin
            r.kind = KIND_TWO_REAL;
        end else begin
            r.kind = KIND_COMPLEX;
        end
        scaled = 128'(disc < 0 ? -disc : disc) << (2 * FB);
        s = longint'(isqrt_floor(scaled));
        den = 2 * a;
        nb = -b * (64'sd1 <<< FB);
        case (r.kind)
            KIND_REPEATED: r.first = clamp_q(nb / den);
            KIND_TWO_REAL: begin
                r.first = clamp_q((nb + s) / den);
                r.second = clamp_q((nb - s) / den);
            end
            default: begin
                r.first = clamp_q(nb / den);
                r.second = clamp_q(s / den);
            end
        endcase
        return r;
    endfunction

    task automatic queue_set(input int a, input int b, input int c);
        t_coefs k;
        k.a = a[CB-1:0];
        k.b = b[CB-1:0];
        k.c = c[CB-1:0];
        pending_sets.push_back(k);
    endtask

    // Driver: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_coefs k;
        logic next_start;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                k.a = i_coef_a;
                k.b = i_coef_b;
                k.c = i_coef_c;
                expected_roots.push_back(solve_roots(k));
                n_sent++;
            end
            next_start = start && busy;
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_sets.size() > 0) begin
                    k = pending_sets.pop_front();
                    i_coef_a <= k.a;
                    i_coef_b <= k.b;
                    i_coef_c <= k.c;
                    next_start = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            start <= next_start;
        end
    end

    // Monitor: results cannot be held off, so check every strobe
    always @(posedge i_clk) begin
        t_roots e;
        if (i_rst_n && o_valid) begin
            if (expected_roots.size() == 0) begin
                $display("%0t: unexpected result kind=%0d first=%0d second=%0d",
                         $time, o_root_kind, o_first_value, o_second_value);
                n_errors++;
            end else begin
                e = expected_roots.pop_front();
                n_checked++;
                kind_seen[e.kind]++;
                if (o_root_kind !== e.kind) begin
                    $display("%0t: root_kind expected %0d actual %0d", $time, e.kind,
                             o_root_kind);
                    n_errors++;
                end
                if (o_first_value !== e.first) begin
                    $display("%0t: first_value expected %0d actual %0d", $time, e.first,
                             o_first_value);
                    n_errors++;
                end
                if (o_second_value !== e.second) begin
                    $display("%0t: second_value expected %0d actual %0d", $time, e.second,
                             o_second_value);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int a;
        int b;
        int c;
        int m;
        // directed: invalid, extremes, each root kind
        queue_set(0, 0, 0);
        queue_set(0, -32768, 32767);
        queue_set(0, 32767, -32768);
        queue_set(1, 2, 1);
        queue_set(-1, 2, -1);
        queue_set(-32768, -32768, -32768);
        queue_set(-32768, -32768, 32767);
        queue_set(32767, 32767, 32767);
        queue_set(32767, -32768, -32768);
        queue_set(-32768, 0, 32767);
        queue_set(1, 0, -1);
        queue_set(1, 0, 1);
        queue_set(2, -3, 1);
        queue_set(-3, 5, 7);
        queue_set(1, -32768, 0);
        queue_set(-1, 0, 0);
        queue_set(32767, 0, 0);
        queue_set(-32768, 32767, 0);
        queue_set(4, 4, 1);
        queue_set(-5, 1, -9);
        for (int i = 0; i < N_RANDOM; i++) begin
            m = $urandom_range(0, 9);
            if (m < 5) begin
                a = $urandom_range(0, 65535) - 32768;
                b = $urandom_range(0, 65535) - 32768;
                c = $urandom_range(0, 65535) - 32768;
            end else if (m < 7) begin
                // repeated root: a*(x+k)^2
                a = $urandom_range(0, 40) - 20;
                if (a == 0) a = 1;
                c = $urandom_range(0, 80) - 40;
                b = 2 * a * c;
                c = a * c * c;
                if (c > 32767 || c < -32768 || b > 32767 || b < -32768) begin
                    a = 1;
                    b = 2;
                    c = 1;
                end
            end else if (m < 9) begin
                a = $urandom_range(0, 200) - 100;
                b = $urandom_range(0, 200) - 100;
                c = $urandom_range(0, 200) - 100;
            end else begin
                a = 0;
                b = $urandom_range(0, 65535) - 32768;
                c = $urandom_range(0, 65535) - 32768;
            end
            queue_set(a, b, c);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_sets.size() == 0 && !start);
        wait (expected_roots.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("sent %0d coefficient sets, checked %0d results", n_sent, n_checked);
        $display("repeated %0d, two real %0d, complex %0d, invalid %0d",
                 kind_seen[KIND_REPEATED], kind_seen[KIND_TWO_REAL],
                 kind_seen[KIND_COMPLEX], kind_seen[KIND_INVALID]);
        if (n_errors == 0 && expected_roots.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire
